@@ rtl/complex_linear_prediction_extrapolator_unit_macros.svh @@
// assertion macros shared by the extrapolator rtl
`ifndef COMPLEX_LINEAR_PREDICTION_EXTRAPOLATOR_UNIT_MACROS_SVH
`define COMPLEX_LINEAR_PREDICTION_EXTRAPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CLPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clpe check failed");

// next-cycle implication
`define CLPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clpe check failed");

`endif

@@ rtl/clpe_pkg.sv @@
// shared constants and types of the linear prediction extrapolator
`default_nettype none

package clpe_pkg;

   localparam int ORDER_MAX  = 32;
   localparam int IDX_W      = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
   localparam int FILL_W     = $clog2(ORDER_MAX + 1);
   localparam int STEP_W     = $clog2(2 * ORDER_MAX);
   localparam int SAMPLE_W   = 24;
   localparam int OP_W       = 2;
   localparam int TAP_W      = 5;
   localparam int ORDER_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int FRAC_W     = 20;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = PROD_W + 1 + IDX_W;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_PUSH    = 2'd1,
      OP_PREDICT = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PRED_ORDER     = 2'd0,
      REG_COMPLEX_MODE   = 2'd1,
      REG_PREDICT_BEFORE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } cplx_type;

   typedef enum logic [1:0] {
      HSEL_HOLD = 2'd0,
      HSEL_NEXT = 2'd1,
      HSEL_PREV = 2'd2,
      HSEL_LOAD = 2'd3
   } hist_sel_type;

   typedef struct packed {
      logic load;
      logic rotate;
   } coef_ctl_type;

   typedef struct packed {
      logic clear;
      logic tap_valid;
      logic cplx;
   } mac_ctl_type;

endpackage

`default_nettype wire

@@ rtl/clpe_if.sv @@
// request, response and register write channel interfaces
`default_nettype none

interface clpe_req_if import clpe_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic [TAP_W-1:0]           tap_index;
   logic signed [SAMPLE_W-1:0] coef_re;
   logic signed [SAMPLE_W-1:0] coef_im;
   logic signed [SAMPLE_W-1:0] sample_re;
   logic signed [SAMPLE_W-1:0] sample_im;

   modport source (output valid, op, tap_index, coef_re, coef_im, sample_re, sample_im,
                   input ready);
   modport sink (input valid, op, tap_index, coef_re, coef_im, sample_re, sample_im,
                 output ready);
endinterface

interface clpe_rsp_if import clpe_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] pred_re;
   logic signed [SAMPLE_W-1:0] pred_im;
   logic                       saturated;

   modport source (output valid, pred_re, pred_im, saturated, input ready);
   modport sink (input valid, pred_re, pred_im, saturated, output ready);
endinterface

interface clpe_csr_if import clpe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/clpe_hist_cell.sv @@
// one history cell: holds a sample and hands it on to a neighbour
`default_nettype none

module clpe_hist_cell import clpe_pkg::*; (
   input  logic         clock,
   input  hist_sel_type sel,
   input  cplx_type     next_data,
   input  cplx_type     prev_data,
   input  cplx_type     load_data,
   output cplx_type     data
);

   cplx_type data_ff;
   cplx_type data_in;

   always_comb begin
      unique case (sel)
         HSEL_HOLD: data_in = data_ff;
         HSEL_NEXT: data_in = next_data;
         HSEL_PREV: data_in = prev_data;
         HSEL_LOAD: data_in = load_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

@@ rtl/clpe_coef_cell.sv @@
// one coefficient cell: holds a tap and rotates it round the ring
`default_nettype none

module clpe_coef_cell import clpe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  coef_ctl_type ctl,
   input  cplx_type     load_data,
   input  cplx_type     next_data,
   output cplx_type     data
);

   cplx_type data_ff;
   cplx_type data_in;

   always_comb begin
      priority if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.rotate) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

@@ rtl/clpe_mac.sv @@
// complex multiply-accumulate with rounding and saturation
`default_nettype none

module clpe_mac import clpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mac_ctl_type ctl,
   input  cplx_type    sample,
   input  cplx_type    coef,
   output cplx_type    pred,
   output logic        saturated
);

   localparam int Q_W = ACC_W + 1 - FRAC_W;
   localparam logic signed [ACC_W:0] HALF =
      {{(ACC_W + 1 - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};
   localparam logic signed [Q_W-1:0] SMAX_Q = Q_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [Q_W-1:0] SMIN_Q = Q_W'(-(2 ** (SAMPLE_W - 1)));
   localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

   logic signed [SAMPLE_W-1:0] sr, si, cr, ci;
   logic signed [PROD_W-1:0]   rr_ff, ii_ff, ri_ff, ir_ff;
   logic                       prod_vld_ff;
   logic signed [ACC_W-1:0]    acc_re_ff, acc_im_ff;
   logic [SAMPLE_W:0]          res_re, res_im;

   function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]   v;
      logic signed [Q_W-1:0]   q;
      logic [SAMPLE_W:0]       r;
      v = (ACC_W + 1)'(acc) + HALF;
      q = v[ACC_W:FRAC_W];
      if (q > SMAX_Q) begin
         r = {1'b1, SMAX};
      end else if (q < SMIN_Q) begin
         r = {1'b1, SMIN};
      end else begin
         r = {1'b0, q[SAMPLE_W-1:0]};
      end
      return r;
   endfunction

   // real mode drops the imaginary parts before the multipliers
   assign sr = $signed(sample.re);
   assign cr = $signed(coef.re);
   assign si = ctl.cplx ? $signed(sample.im) : '0;
   assign ci = ctl.cplx ? $signed(coef.im) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.tap_valid;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff <= sr * cr;
      ii_ff <= si * ci;
      ri_ff <= sr * ci;
      ir_ff <= si * cr;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(rr_ff) - ACC_W'(ii_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(ri_ff) + ACC_W'(ir_ff);
      end
   end

   assign res_re    = round_sat(acc_re_ff);
   assign res_im    = round_sat(acc_im_ff);
   assign pred.re   = $signed(res_re[SAMPLE_W-1:0]);
   assign pred.im   = $signed(res_im[SAMPLE_W-1:0]);
   assign saturated = res_re[SAMPLE_W] | res_im[SAMPLE_W];

endmodule

`default_nettype wire

@@ rtl/complex_linear_prediction_extrapolator_unit.sv @@
// top level of the linear prediction extrapolator: coefficient ring, history ring, mac
// load and push beats leave the unit idle, ready stays high after them
// predict: the run state turns the history ring and, from step t0, the coefficient ring once
// round, then the drain and finish states register the response and free the next request;
// t0 = 0 in before mode or with no samples, else ORDER_MAX - fill; an untaken response holds the next predict
// synchronous reset: defaults in the registers, coefficients zero, history empty
`default_nettype none
`include "complex_linear_prediction_extrapolator_unit_macros.svh"

module complex_linear_prediction_extrapolator_unit import clpe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   clpe_req_if.sink   req_if,
   clpe_rsp_if.source rsp_if,
   clpe_csr_if.sink   csr_if
);

   localparam int CMP_A = (STEP_W > FILL_W) ? STEP_W : FILL_W;
   localparam int CMP_W = (CMP_A > ORDER_W) ? CMP_A : ORDER_W;
   localparam int TAPC_W = (TAP_W > IDX_W) ? TAP_W : IDX_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_RUN    = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [IDX_W-1:0]     t0_ff, t0_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [ORDER_W-1:0]   pred_order_ff;
   logic                 complex_mode_ff;
   logic                 predict_before_ff;
   logic                 rsp_vld_ff;
   cplx_type             rsp_data_ff;
   logic                 rsp_sat_ff;

   cplx_type     hist_data [ORDER_MAX];
   cplx_type     hist_next [ORDER_MAX];
   cplx_type     hist_prev [ORDER_MAX];
   hist_sel_type hist_sel  [ORDER_MAX];
   cplx_type     coef_data [ORDER_MAX];
   coef_ctl_type coef_ctl  [ORDER_MAX];

   logic         req_beat, load_beat, push_beat, pred_beat;
   logic         running, hist_rot, coef_rot, run_last, finish_go;
   logic         put_now, put_is_pred, put_load, fill_full;
   hist_sel_type hist_glob;
   cplx_type     put_data, req_sample, req_coef, head_sample, mac_pred;
   logic         mac_sat;
   mac_ctl_type  mac_ctl;
   logic [STEP_W-1:0] tap_j, last_step;
   logic [CMP_W-1:0]  ord_ext, order_eff;

   // handshakes
   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_beat  = req_if.valid && req_if.ready;
   assign load_beat = req_beat && (req_if.op == OP_LOAD);
   assign push_beat = req_beat && (req_if.op == OP_PUSH);
   assign pred_beat = req_beat && (req_if.op == OP_PREDICT);

   assign req_sample.re = req_if.sample_re;
   assign req_sample.im = req_if.sample_im;
   assign req_coef.re   = req_if.coef_re;
   assign req_coef.im   = req_if.coef_im;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pred_order_ff     <= '0;
         complex_mode_ff   <= 1'b1;
         predict_before_ff <= 1'b0;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            REG_PRED_ORDER:     pred_order_ff     <= csr_if.data[ORDER_W-1:0];
            REG_COMPLEX_MODE:   complex_mode_ff   <= csr_if.data[0];
            REG_PREDICT_BEFORE: predict_before_ff <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   // sequencing of the two rings
   assign running   = (state_ff == S_RUN);
   assign last_step = STEP_W'(t0_ff) + STEP_W'(ORDER_MAX - 1);
   assign run_last  = running && (step_ff == last_step);
   assign hist_rot  = running && (step_ff < STEP_W'(ORDER_MAX));
   assign coef_rot  = running && (step_ff >= STEP_W'(t0_ff));
   assign tap_j     = step_ff - STEP_W'(t0_ff);
   assign ord_ext   = CMP_W'(pred_order_ff);
   assign order_eff = (ord_ext > CMP_W'(ORDER_MAX)) ? CMP_W'(ORDER_MAX) : ord_ext;
   assign finish_go = (state_ff == S_FINISH) && (!rsp_vld_ff || rsp_if.ready);
   assign fill_full = (fill_ff == FILL_W'(ORDER_MAX));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      t0_in    = t0_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pred_beat) begin
               state_in = S_RUN;
               step_in  = '0;
               if (predict_before_ff || (fill_ff == '0)) begin
                  t0_in = '0;
               end else begin
                  t0_in = IDX_W'(FILL_W'(ORDER_MAX) - fill_ff);
               end
            end
         end
         S_RUN: begin
            step_in = step_ff + STEP_W'(1);
            if (run_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (finish_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         t0_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         t0_ff    <= t0_in;
         fill_ff  <= fill_in;
      end
   end

   // history writes
   assign put_is_pred = finish_go;
   assign put_now     = push_beat || finish_go;
   assign put_data    = finish_go ? mac_pred : req_sample;

   always_comb begin
      hist_glob = HSEL_HOLD;
      put_load  = 1'b0;
      if (hist_rot) begin
         hist_glob = predict_before_ff ? HSEL_NEXT : HSEL_PREV;
      end else if (put_now) begin
         priority if (put_is_pred && predict_before_ff) begin
            hist_glob = HSEL_PREV;
         end else if (!fill_full) begin
            put_load = 1'b1;
         end else if (!predict_before_ff) begin
            hist_glob = HSEL_NEXT;
         end else begin
            hist_glob = HSEL_HOLD;
         end
      end
   end

   assign fill_in = (put_now && !fill_full) ? fill_ff + FILL_W'(1) : fill_ff;

   for (genvar k = 0; k < ORDER_MAX; k++) begin : g_cell
      if (k == ORDER_MAX - 1) begin : g_last
         assign hist_next[k] = hist_rot ? hist_data[0] : put_data;
         assign coef_ctl[k].rotate = coef_rot;
         clpe_coef_cell u_coef (
            .clock     (clock),
            .reset     (reset),
            .ctl       (coef_ctl[k]),
            .load_data (req_coef),
            .next_data (coef_data[0]),
            .data      (coef_data[k])
         );
      end else begin : g_mid
         assign hist_next[k] = hist_data[k+1];
         assign coef_ctl[k].rotate = coef_rot;
         clpe_coef_cell u_coef (
            .clock     (clock),
            .reset     (reset),
            .ctl       (coef_ctl[k]),
            .load_data (req_coef),
            .next_data (coef_data[k+1]),
            .data      (coef_data[k])
         );
      end
      if (k == 0) begin : g_first
         assign hist_prev[k] = hist_rot ? hist_data[ORDER_MAX-1] : put_data;
      end else begin : g_rest
         assign hist_prev[k] = hist_data[k-1];
      end
      assign coef_ctl[k].load = load_beat &&
                                (TAPC_W'(req_if.tap_index) == TAPC_W'(k));
      assign hist_sel[k] = (put_load && (fill_ff == FILL_W'(k))) ? HSEL_LOAD : hist_glob;
      clpe_hist_cell u_hist (
         .clock     (clock),
         .sel       (hist_sel[k]),
         .next_data (hist_next[k]),
         .prev_data (hist_prev[k]),
         .load_data (put_data),
         .data      (hist_data[k])
      );
   end

   // head of the rings feeds the mac
   assign head_sample     = predict_before_ff ? hist_data[0] : hist_data[ORDER_MAX-1];
   assign mac_ctl.clear     = pred_beat;
   assign mac_ctl.cplx      = complex_mode_ff;
   assign mac_ctl.tap_valid = coef_rot && (CMP_W'(tap_j) < CMP_W'(fill_ff)) &&
                              (CMP_W'(tap_j) < order_eff);

   clpe_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .sample    (head_sample),
      .coef      (coef_data[0]),
      .pred      (mac_pred),
      .saturated (mac_sat)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_data_ff <= mac_pred;
         rsp_sat_ff  <= mac_sat;
      end
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.pred_re   = rsp_data_ff.re;
   assign rsp_if.pred_im   = rsp_data_ff.im;
   assign rsp_if.saturated = rsp_sat_ff;

   `CLPE_ASSERT_NEXT(a_pred_starts, clock, reset, pred_beat, state_ff == S_RUN)
   `CLPE_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(ORDER_MAX))
   `CLPE_ASSERT_IMPLY(a_step_bound, clock, reset, state_ff == S_RUN, step_ff <= last_step)
   `CLPE_ASSERT_NEXT(a_result_loaded, clock, reset, finish_go, rsp_vld_ff)
   `CLPE_ASSERT_IMPLY(a_tap_in_range, clock, reset, mac_ctl.tap_valid, tap_j < STEP_W'(ORDER_MAX))

endmodule

`default_nettype wire
